>>> src/sorted_insert_queue_assert.svh
// Assertion macros for the sorted insert queue checker.
`ifndef SORTED_INSERT_QUEUE_ASSERT_SVH
`define SORTED_INSERT_QUEUE_ASSERT_SVH

// Clocked assertion, masked while reset is active.
`define SIQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SIQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> src/siq_pkg.sv
// Shared constants and types for the sorted insert queue.
package siq_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned KIND_W = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OUT_W  = ((DATA_W + CNT_W + 7) / 8) * 8;

  localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INS  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // Per-transaction command broadcast to every cell.
  typedef struct packed {
    logic push;
    logic ins;
    logic pop;
  } siq_ctrl_t;

endpackage

>>> src/siq_cell.sv
// One storage cell of the queue: holds an entry and shifts left, right or loads.
module siq_cell (
  input  logic                     clk_i,
  input  siq_pkg::siq_ctrl_t       ctrl_i,
  input  logic                     valid_i,
  input  logic [siq_pkg::DATA_W-1:0] value_i,
  input  logic [siq_pkg::DATA_W-1:0] left_i,
  input  logic [siq_pkg::DATA_W-1:0] right_i,
  input  logic                     found_i,
  output logic                     found_o,
  output logic [siq_pkg::DATA_W-1:0] entry_o
);
  import siq_pkg::*;

  logic [DATA_W-1:0] entry_q, entry_d;
  logic              here;

  // Insert point: an empty slot, a greater entry, or the front for a push.
  assign here    = ctrl_i.push | ~valid_i | (entry_q > value_i);
  assign found_o = found_i | here;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.push || ctrl_i.ins) begin
      if (found_i) begin
        entry_d = left_i;
      end else if (here) begin
        entry_d = value_i;
      end
    end else if (ctrl_i.pop) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

>>> src/sorted_insert_queue.sv
// Top level of the sorted insert queue: cell row, occupancy counter, result register.
//
// Holds up to DEPTH 32-bit values in a row of cells, front first. Every cell
// sees each push, sorted insert or pop at once and updates its entry in the
// same clock, so one transaction is taken per cycle while ready, and its result
// appears on the master side in the next cycle. The result register is the only
// buffering: the slave side stalls only while a result waits to be taken.
module sorted_insert_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [siq_pkg::DATA_W-1:0] s_axis_tdata,   // [31:0] value
  input  logic [siq_pkg::KIND_W-1:0] s_axis_tuser,   // [1:0] kind
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [siq_pkg::OUT_W-1:0]  m_axis_tdata,   // [31:0] popped_value, [36:32] occupancy
  output logic [siq_pkg::STAT_W-1:0] m_axis_tuser    // [1:0] status
);
  import siq_pkg::*;

  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q, out_valid_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic [DATA_W-1:0] popped_q, popped_d;
  logic [CNT_W-1:0]  occ_q;

  logic              accept, full, empty;
  siq_ctrl_t         ctrl;
  logic [DEPTH-1:0]  valid;
  logic [DEPTH:0]    found;
  logic [DATA_W-1:0] entry [DEPTH];

  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign full          = (count_q == CNT_W'(DEPTH));
  assign empty         = (count_q == '0);

  assign ctrl.push = accept & (s_axis_tuser == KIND_PUSH) & ~full;
  assign ctrl.ins  = accept & (s_axis_tuser == KIND_INS) & ~full;
  assign ctrl.pop  = accept & (s_axis_tuser == KIND_POP) & ~empty;

  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left, right;
    assign valid[i] = (CNT_W'(i) < count_q);
    if (i == 0) begin : g_first
      assign left = s_axis_tdata;
    end else begin : g_mid_l
      assign left = entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = entry[i];
    end else begin : g_mid_r
      assign right = entry[i+1];
    end
    siq_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .valid_i (valid[i]),
      .value_i (s_axis_tdata),
      .left_i  (left),
      .right_i (right),
      .found_i (found[i]),
      .found_o (found[i+1]),
      .entry_o (entry[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_OK;
    popped_d = '0;
    case (s_axis_tuser)
      KIND_PUSH, KIND_INS: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      KIND_POP: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          popped_d = entry[0];
          count_d  = count_q - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      popped_q <= popped_d;
      occ_q    <= count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {(OUT_W - DATA_W - CNT_W)'(0), occ_q, popped_q};

endmodule

>>> src/siq_checker.sv
// Port-level checker for the sorted insert queue, bound to the top level.
`include "sorted_insert_queue_assert.svh"

module siq_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic [siq_pkg::DATA_W-1:0] s_axis_tdata,
  input logic [siq_pkg::KIND_W-1:0] s_axis_tuser,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [siq_pkg::OUT_W-1:0]  m_axis_tdata,
  input logic [siq_pkg::STAT_W-1:0] m_axis_tuser
);
  import siq_pkg::*;

  logic [CNT_W-1:0]  occ;
  logic [DATA_W-1:0] popped;

  assign occ    = m_axis_tdata[DATA_W +: CNT_W];
  assign popped = m_axis_tdata[DATA_W-1:0];

  `SIQ_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
  `SIQ_ASSERT(a_occ_range, m_axis_tvalid |-> occ <= CNT_W'(DEPTH), "occupancy beyond depth")
  `SIQ_ASSERT(a_full_occ, m_axis_tvalid && m_axis_tuser == ST_FULL |-> occ == CNT_W'(DEPTH), "full status with room left")
  `SIQ_ASSERT(a_empty_occ, m_axis_tvalid && m_axis_tuser == ST_EMPTY |-> occ == '0 && popped == '0, "empty status with data")

endmodule

bind sorted_insert_queue siq_checker u_siq_checker (.*);
